>>> rtl/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg: shared types, constants and tables of the pager codeword decoder
// Codeword constants, result beat layout, decoder state and character tables.
// ----------------------------------------------------------------------------
package pcd_pkg;

	localparam int MAX_CHARS_DEF = 256;
	localparam int MAX_RES       = 5;    // most results one codeword can cause
	localparam int RES_CNT_W     = $clog2(MAX_RES + 1);
	localparam int RES_IDX_W     = $clog2(MAX_RES);

	localparam logic [31:0] SYNC_WORD = 32'h7cd2_15d8;
	localparam logic [31:0] IDLE_WORD = 32'h7a89_c197;
	localparam logic [31:0] BCH_GEN   = 32'h7690_0000;

	// configuration register indexes
	localparam logic CFG_NUMERIC = 1'b0;
	localparam logic CFG_ALPHA   = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [6:0]  character;
		logic [21:0] pager_address;
		logic [1:0]  function_code;
		logic [8:0]  char_total;
		logic        last;
	} result_t;

	// message state; pend holds the not yet complete text bits, first bit at bit 0,
	// bits at and above bit_pos are zero
	typedef struct packed {
		logic        msg_open;
		logic [21:0] address;
		logic [1:0]  func;
		logic [2:0]  bit_pos;
		logic [5:0]  pend;
	} state_t;

	// check bits contributed by each of the 21 information bits
	function automatic logic [20:0][9:0] bch_cols();
		logic [20:0][9:0] cols;
		logic [30:0]      w;
		logic [30:0]      g;
		for (int k = 0; k < 21; k++) begin
			w = 31'(1) << (k + 10);
			g = BCH_GEN[30:0];
			for (int i = 0; i < 21; i++) begin
				if (w[30 - i]) begin
					w = w ^ g;
				end
				g = g >> 1;
			end
			cols[k] = w[9:0];
		end
		return cols;
	endfunction

	localparam logic [20:0][9:0] BCH_COLS = bch_cols();

	function automatic logic [6:0] hex_char(input logic [3:0] d);
		logic [6:0] c;
		if (d < 4'd10) begin
			c = 7'h30 + {3'b000, d};
		end else begin
			c = 7'h57 + {3'b000, d};
		end
		return c;
	endfunction

	function automatic logic [6:0] numeric_char(input logic [3:0] d);
		logic [6:0] c;
		unique case (d)
			4'hA:    c = 7'h52; // R
			4'hB:    c = 7'h55; // U
			4'hC:    c = 7'h20; // space
			4'hD:    c = 7'h2d; // -
			4'hE:    c = 7'h5d; // ]
			4'hF:    c = 7'h5b; // [
			default: c = 7'h30 + {3'b000, d};
		endcase
		return c;
	endfunction

endpackage

>>> rtl/pcd_word_if.sv
// ----------------------------------------------------------------------------
// pcd_word_if: codeword channel
// One beat carries a received codeword and its frame slot.
// ----------------------------------------------------------------------------
interface pcd_word_if;
	logic              valid;
	logic              ready;
	logic [31:0]       codeword;
	logic signed [3:0] frame_slot;

	modport source (output valid, codeword, frame_slot, input ready);
	modport sink   (input valid, codeword, frame_slot, output ready);
endinterface

>>> rtl/pcd_result_if.sv
// ----------------------------------------------------------------------------
// pcd_result_if: result channel
// One beat carries a decoded character or an end of message record.
// ----------------------------------------------------------------------------
interface pcd_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [6:0]  character;
	logic [21:0] pager_address;
	logic [1:0]  function_code;
	logic [8:0]  char_total;
	logic        last;

	modport source (output valid, kind, character, pager_address, function_code,
		char_total, last, input ready);
	modport sink   (input valid, kind, character, pager_address, function_code,
		char_total, last, output ready);
endinterface

>>> rtl/pager_codeword_receive_decoder_unit.sv
// ----------------------------------------------------------------------------
// pager_codeword_receive_decoder_unit: paging codeword decoder top level
// Accepts codewords, checks BCH and parity, streams characters and end records.
// ----------------------------------------------------------------------------
// A codeword is registered in the input register on acceptance and is decoded into
// the result buffer once that buffer is free; its first beat is then offered from there.
// One codeword per cycle when each causes at most one result and the result side is
// ready; otherwise the single-read result buffer, holding up to 5 beats, stalls input.
// Reset (arst_n low, asynchronous): no message open, buffers empty, numeric code 0,
// text code 3.
module pager_codeword_receive_decoder_unit #(
	parameter int MAX_CHARS = pcd_pkg::MAX_CHARS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pcd_word_if.sink   words,
	pcd_result_if.source results,
	input  logic       cfg_wr_en,
	input  logic       cfg_index,
	input  logic [1:0] cfg_data
);
	import pcd_pkg::*;

	localparam int CW = $clog2(MAX_CHARS + 1);

	// configuration registers
	logic [1:0] numeric_code_q;
	logic [1:0] alpha_code_q;

	// input stage
	logic              valid_s1;
	logic [31:0]       codeword_s1;
	logic signed [3:0] slot_s1;

	// message state
	state_t        state_q;
	logic [CW-1:0] chars_q;

	// decode outputs
	result_t [MAX_RES-1:0] batch;
	logic [RES_CNT_W-1:0]  batch_len;
	state_t                state_nxt;
	logic [CW-1:0]         chars_nxt;

	// result buffer: entry 0 is the beat on offer, pop shifts down
	result_t [MAX_RES-1:0] res_q;
	logic [RES_CNT_W-1:0]  buf_cnt_q;

	logic pop;
	logic buf_free;
	logic consume;
	logic accept;

	assign pop      = results.valid && results.ready;
	assign buf_free = (buf_cnt_q == '0) || ((buf_cnt_q == RES_CNT_W'(1)) && pop);
	assign consume  = valid_s1 && buf_free;
	assign words.ready = !valid_s1 || consume;
	assign accept   = words.valid && words.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numeric_code_q <= 2'd0;
			alpha_code_q   <= 2'd3;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_NUMERIC: numeric_code_q <= cfg_data;
				CFG_ALPHA:   alpha_code_q   <= cfg_data;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (words.ready) begin
			valid_s1 <= words.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			codeword_s1 <= words.codeword;
			slot_s1     <= words.frame_slot;
		end
	end

	pcd_decode #(
		.MAX_CHARS (MAX_CHARS)
	) u_decode (
		.codeword     (codeword_s1),
		.frame_slot   (slot_s1),
		.numeric_code (numeric_code_q),
		.alpha_code   (alpha_code_q),
		.state_cur    (state_q),
		.chars_cur    (chars_q),
		.batch        (batch),
		.batch_len    (batch_len),
		.state_nxt    (state_nxt),
		.chars_nxt    (chars_nxt)
	);

	// message state advances when the staged word moves into the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			chars_q <= '0;
		end else if (consume) begin
			state_q <= state_nxt;
			chars_q <= chars_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_cnt_q <= '0;
		end else if (consume) begin
			buf_cnt_q <= batch_len;
		end else if (pop) begin
			buf_cnt_q <= buf_cnt_q - RES_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			res_q <= batch;
		end else if (pop) begin
			res_q <= res_q >> $bits(result_t);
		end
	end

	assign results.valid         = (buf_cnt_q != '0);
	assign results.kind          = res_q[0].kind;
	assign results.character     = res_q[0].character;
	assign results.pager_address = res_q[0].pager_address;
	assign results.function_code = res_q[0].function_code;
	assign results.char_total    = res_q[0].char_total;
	assign results.last          = res_q[0].last;

`ifndef SYNTHESIS
	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		buf_cnt_q <= RES_CNT_W'(MAX_RES))
		else $error("result buffer count out of range");

	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.last == (buf_cnt_q == RES_CNT_W'(1))))
		else $error("last flag not on the final beat of a codeword");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		consume |-> ((buf_cnt_q == '0) || ((buf_cnt_q == RES_CNT_W'(1)) && pop)))
		else $error("buffer loaded while beats still pending");

	a_bitpos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bit_pos <= 3'd6)
		else $error("text bit position out of range");

	a_char_limit: assert property (@(posedge clk) disable iff (!arst_n)
		chars_q <= CW'(MAX_CHARS))
		else $error("character count beyond buffer limit");
`endif

endmodule

>>> rtl/pcd_decode.sv
// ----------------------------------------------------------------------------
// pcd_decode: codeword decode logic
// Checks one codeword, builds its batch of result beats and the next state.
// ----------------------------------------------------------------------------
module pcd_decode #(
	parameter int MAX_CHARS = pcd_pkg::MAX_CHARS_DEF,
	localparam int CW = $clog2(MAX_CHARS + 1)
) (
	input  logic [31:0]                                 codeword,
	input  logic signed [3:0]                           frame_slot,
	input  logic [1:0]                                  numeric_code,
	input  logic [1:0]                                  alpha_code,
	input  pcd_pkg::state_t                             state_cur,
	input  logic [CW-1:0]                               chars_cur,
	output pcd_pkg::result_t [pcd_pkg::MAX_RES-1:0]     batch,
	output logic [pcd_pkg::RES_CNT_W-1:0]               batch_len,
	output pcd_pkg::state_t                             state_nxt,
	output logic [CW-1:0]                               chars_nxt
);
	import pcd_pkg::*;

	localparam logic [CW-1:0] MAX_C = CW'(MAX_CHARS);

	logic [9:0]    syndrome;
	logic          word_ok;
	logic          sync_skip;
	logic [7:0]    slot8;
	logic [21:0]   new_addr;
	logic [CW-1:0] room;
	logic          is_num;
	logic          is_alpha;
	logic [2:0]    n_num;
	logic [1:0]    n_alpha;
	logic          p3;
	logic [26:0]   stream;
	logic [19:0]   rev;
	result_t       end_item;

	always_comb begin
		syndrome = '0;
		for (int k = 0; k < 21; k++) begin
			if (codeword[11 + k]) begin
				syndrome = syndrome ^ BCH_COLS[k];
			end
		end
	end

	assign word_ok   = (syndrome == codeword[10:1]) && !(^codeword) && (codeword != IDLE_WORD);
	assign sync_skip = frame_slot[3] && (codeword == SYNC_WORD);
	assign slot8     = {{4{frame_slot[3]}}, frame_slot};
	assign new_addr  = 22'({codeword[30:13], 3'b000}) + 22'(slot8);
	assign room      = MAX_C - chars_cur;
	assign is_num    = (state_cur.func == numeric_code);
	assign is_alpha  = !is_num && (state_cur.func == alpha_code);

	// numeric / hex: five digits, text: two or three characters depending on carry-in
	assign n_num   = (room < CW'(5)) ? 3'(room) : 3'd5;
	assign p3      = (state_cur.bit_pos != 3'd0);
	assign n_alpha = (room < CW'({1'b1, p3})) ? 2'(room) : {1'b1, p3};

	// text bit stream: carried bits first, then word bits 30 down to 11
	always_comb begin
		for (int i = 0; i < 20; i++) begin
			rev[i] = codeword[30 - i];
		end
	end
	assign stream = (27'(rev) << state_cur.bit_pos) | 27'(state_cur.pend);

	always_comb begin
		end_item               = '0;
		end_item.kind          = 1'b1;
		end_item.pager_address = state_cur.address;
		end_item.function_code = state_cur.func;
		end_item.char_total    = 9'(chars_cur);
	end

	always_comb begin
		batch     = '0;
		batch_len = '0;
		state_nxt = state_cur;
		chars_nxt = chars_cur;
		priority if (sync_skip) begin
			batch_len = '0;
		end else if (!word_ok || !codeword[31]) begin
			if (state_cur.msg_open) begin
				batch[0]  = end_item;
				batch_len = RES_CNT_W'(1);
			end
			state_nxt.msg_open = 1'b0;
			if (word_ok) begin
				// address word opens a new message
				state_nxt.msg_open = 1'b1;
				state_nxt.address  = new_addr;
				state_nxt.func     = codeword[12:11];
				state_nxt.bit_pos  = '0;
				state_nxt.pend     = '0;
				chars_nxt          = '0;
			end
		end else if (state_cur.msg_open) begin
			if (!is_alpha) begin
				for (int k = 0; k < MAX_RES; k++) begin
					if (3'(k) < n_num) begin
						batch[k].character = is_num
							? numeric_char({codeword[27 - 4*k], codeword[28 - 4*k],
								codeword[29 - 4*k], codeword[30 - 4*k]})
							: hex_char({codeword[27 - 4*k], codeword[28 - 4*k],
								codeword[29 - 4*k], codeword[30 - 4*k]});
					end
				end
				batch_len = RES_CNT_W'(n_num);
				chars_nxt = chars_cur + CW'(n_num);
			end else if (room != '0) begin
				for (int k = 0; k < 3; k++) begin
					if (2'(k) < n_alpha) begin
						batch[k].character = stream[7*k +: 7];
					end
				end
				batch_len = RES_CNT_W'(n_alpha);
				chars_nxt = chars_cur + CW'(n_alpha);
				if (room <= CW'({1'b1, p3})) begin
					// buffer filled: assembler halts right after the last character
					state_nxt.bit_pos = '0;
					state_nxt.pend    = '0;
				end else if (p3) begin
					state_nxt.bit_pos = state_cur.bit_pos - 3'd1;
					state_nxt.pend    = stream[21 +: 6];
				end else begin
					state_nxt.bit_pos = 3'd6;
					state_nxt.pend    = stream[14 +: 6];
				end
			end
		end
		if (batch_len != '0) begin
			batch[RES_IDX_W'(batch_len - RES_CNT_W'(1))].last = 1'b1;
		end
	end

endmodule
